### rtl/grid_bfs_path_search_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid path search block
// Shared shorthand for clocked checks; clock clk, reset arst_n.
// ---------------------------------------------------------------------------
`ifndef GRID_BFS_PATH_SEARCH_MACROS_SVH
`define GRID_BFS_PATH_SEARCH_MACROS_SVH

// checked on every edge outside reset
`define GBPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on the next cycle, outside reset
`define GBPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/gbps_pkg.sv
// ---------------------------------------------------------------------------
// gbps_pkg
// Types and constants shared by the grid path search block.
// ---------------------------------------------------------------------------
package gbps_pkg;

	localparam int GRID_W_DEF = 32;
	localparam int GRID_H_DEF = 32;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int COORD_W = 5;
	localparam int LEN_W   = 10;
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_MAX = 1023;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_SEARCH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 2'd3;

	// neighbour directions, in search order
	localparam logic [1:0] DIR_PX = 2'd0;
	localparam logic [1:0] DIR_PY = 2'd1;
	localparam logic [1:0] DIR_MX = 2'd2;
	localparam logic [1:0] DIR_MY = 2'd3;

endpackage

### rtl/gbps_cmd_if.sv
// ---------------------------------------------------------------------------
// gbps_cmd_if
// Command channel: one word per operation, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gbps_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [gbps_pkg::OP_W-1:0]       operation;
	logic [gbps_pkg::COORD_W-1:0]    cell_x;
	logic [gbps_pkg::COORD_W-1:0]    cell_y;
	logic                            blocked;
	logic [gbps_pkg::LEN_W-1:0]      step_index;

	modport source (output valid, operation, cell_x, cell_y, blocked, step_index,
		input ready);
	modport sink (input valid, operation, cell_x, cell_y, blocked, step_index,
		output ready);
endinterface

### rtl/gbps_rsp_if.sv
// ---------------------------------------------------------------------------
// gbps_rsp_if
// Response channel: one word per command, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gbps_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [gbps_pkg::LEN_W-1:0]      path_length;
	logic [gbps_pkg::COORD_W-1:0]    step_x;
	logic [gbps_pkg::COORD_W-1:0]    step_y;
	logic                            step_valid;

	modport source (output valid, found, path_length, step_x, step_y, step_valid,
		input ready);
	modport sink (input valid, found, path_length, step_x, step_y, step_valid,
		output ready);
endinterface

### rtl/grid_bfs_path_search.sv
// ---------------------------------------------------------------------------
// grid_bfs_path_search
// Breadth-first shortest path on an obstacle grid, with path read-back.
// ---------------------------------------------------------------------------
// Usage: cmd carries one word per operation (write obstacle, clear all,
// search, read path step); rsp returns exactly one word per command with the
// last search result and, for a read, the requested step. Start and end
// cells are to be set by the user through the cfg write port only while the
// block is idle; the block itself does not enforce this.
// Clear all sweeps every one of the 2^AW obstacle map entries, where AW is
// the cell address width (2^AW is 1024 for 32x32).
// A search clears the discovered map, checks the start cell, then pops each
// reached cell and tries its four neighbours in turn; at the end cell it walks
// the path back to the start once to count the steps and again to store them.
// The single registered read port of each cell memory paces every step.
// One command is in work at a time; cmd.ready is high only while idle.
// A finished word waits in the output register; the next command is taken
// meanwhile, and its result waits until rsp is taken.
// After reset the obstacle map is swept clear before cmd.ready rises;
// result found and length reset to zero.
// ---------------------------------------------------------------------------
module grid_bfs_path_search #(
	parameter int GRID_W = gbps_pkg::GRID_W_DEF,
	parameter int GRID_H = gbps_pkg::GRID_H_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gbps_cmd_if.sink                          cmd,
	gbps_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [gbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gbps_pkg::CFG_W-1:0]        cfg_data
);

	`include "grid_bfs_path_search_macros.svh"

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int TW    = $clog2(CELLS + 1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_CLRO, ST_CLRD, ST_CHK, ST_CHKW, ST_POP, ST_POPW,
		ST_NB, ST_NBW, ST_CNT, ST_CNTW, ST_WR, ST_WRW, ST_RDW, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [gbps_pkg::CFG_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

	// sequencer registers
	logic [AW-1:0]   clr_q;
	logic [TW-1:0]   head_q, tail_q, cnt_q, pos_q;
	logic [XW-1:0]   cur_x_q, walk_x_q;
	logic [YW-1:0]   cur_y_q, walk_y_q;
	logic [1:0]      dir_q;
	logic            res_found_q;
	logic [gbps_pkg::LEN_W-1:0] res_len_q;
	logic [gbps_pkg::COORD_W-1:0] stp_x_q, stp_y_q;
	logic            stp_valid_q;

	// output register
	logic            out_valid_q, out_found_q, out_stp_valid_q;
	logic [gbps_pkg::LEN_W-1:0] out_len_q;
	logic [gbps_pkg::COORD_W-1:0] out_x_q, out_y_q;
	logic            load_out;

	// memories
	logic            obst_mem [DEPTH];
	logic            disc_mem [DEPTH];
	logic [1:0]      par_mem  [DEPTH];
	logic [AW-1:0]   queue_mem[DEPTH];
	logic [AW-1:0]   path_mem [DEPTH];
	logic            obst_rd_q, disc_rd_q;
	logic [1:0]      par_rd_q;
	logic [AW-1:0]   queue_rd_q, path_rd_q;

	logic            obst_we, obst_wd, disc_we, disc_wd, par_we, queue_we, path_we;
	logic [AW-1:0]   obst_wa, disc_wa, par_wa, queue_wa, queue_wd, path_wa, path_wd;
	logic [AW-1:0]   cell_ra, queue_ra, path_ra;

	logic            accept, bounds_ok, cell_ok, nb_ok, take, walk_at_s, len_sat;
	logic [XW-1:0]   sx, ex, nb_x, back_x;
	logic [YW-1:0]   sy, ey, nb_y, back_y;
	logic [AW-1:0]   s_addr, e_addr, nb_addr, walk_addr;
	gbps_pkg::op_t   op;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign op        = gbps_pkg::op_t'(cmd.operation);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// start / end cell addresses and range check
	assign bounds_ok = (int'(start_x_q) < GRID_W) && (int'(start_y_q) < GRID_H) &&
		(int'(end_x_q) < GRID_W) && (int'(end_y_q) < GRID_H);
	assign sx = XW'(start_x_q);
	assign sy = YW'(start_y_q);
	assign ex = XW'(end_x_q);
	assign ey = YW'(end_y_q);
	assign s_addr = {sy, sx};
	assign e_addr = {ey, ex};
	assign cell_ok = (int'(cmd.cell_x) < GRID_W) && (int'(cmd.cell_y) < GRID_H);

	// neighbour of the current cell in the current direction
	always_comb begin
		nb_x  = cur_x_q;
		nb_y  = cur_y_q;
		nb_ok = 1'b0;
		unique case (dir_q)
			gbps_pkg::DIR_PX: begin
				nb_ok = (cur_x_q != XW'(GRID_W - 1));
				nb_x  = cur_x_q + XW'(1);
			end
			gbps_pkg::DIR_PY: begin
				nb_ok = (cur_y_q != YW'(GRID_H - 1));
				nb_y  = cur_y_q + YW'(1);
			end
			gbps_pkg::DIR_MX: begin
				nb_ok = (cur_x_q != '0);
				nb_x  = cur_x_q - XW'(1);
			end
			default: begin
				nb_ok = (cur_y_q != '0);
				nb_y  = cur_y_q - YW'(1);
			end
		endcase
	end
	assign nb_addr = {nb_y, nb_x};
	assign take    = !disc_rd_q && !obst_rd_q && (tail_q < TW'(CELLS));

	// one step back towards the start along the stored parent direction
	always_comb begin
		back_x = walk_x_q;
		back_y = walk_y_q;
		unique case (par_rd_q)
			gbps_pkg::DIR_PX: back_x = walk_x_q - XW'(1);
			gbps_pkg::DIR_PY: back_y = walk_y_q - YW'(1);
			gbps_pkg::DIR_MX: back_x = walk_x_q + XW'(1);
			default:          back_y = walk_y_q + YW'(1);
		endcase
	end
	assign walk_addr = {walk_y_q, walk_x_q};
	assign walk_at_s = (walk_addr == s_addr);
	assign len_sat   = (int'(cnt_q) > gbps_pkg::LEN_MAX);

	// memory port steering
	always_comb begin
		obst_we  = 1'b0;
		obst_wa  = clr_q;
		obst_wd  = 1'b0;
		disc_we  = 1'b0;
		disc_wa  = clr_q;
		disc_wd  = 1'b0;
		par_we   = (state_q == ST_NBW) && take;
		par_wa   = nb_addr;
		queue_we = 1'b0;
		queue_wa = AW'(tail_q);
		queue_wd = nb_addr;
		path_we  = (state_q == ST_WR) && !walk_at_s && (pos_q != '0);
		path_wa  = AW'(pos_q - TW'(1));
		path_wd  = walk_addr;
		cell_ra  = nb_addr;
		unique case (state_q)
			ST_INIT, ST_CLRO: obst_we = 1'b1;
			ST_IDLE: begin
				obst_we = accept && (op == gbps_pkg::OP_WRITE) && cell_ok;
				obst_wa = {YW'(cmd.cell_y), XW'(cmd.cell_x)};
				obst_wd = cmd.blocked;
			end
			ST_CLRD: disc_we = 1'b1;
			ST_CHK: cell_ra = s_addr;
			ST_CHKW: begin
				disc_we  = !obst_rd_q;
				disc_wa  = s_addr;
				disc_wd  = 1'b1;
				queue_we = !obst_rd_q;
				queue_wa = '0;
				queue_wd = s_addr;
			end
			ST_NBW: begin
				disc_we  = take;
				disc_wa  = nb_addr;
				disc_wd  = 1'b1;
				queue_we = take;
			end
			ST_CNT, ST_WR: cell_ra = walk_addr;
			default: ;
		endcase
	end
	assign queue_ra = AW'(head_q);
	assign path_ra  = AW'(cmd.step_index);

	// cell memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (obst_we) obst_mem[obst_wa] <= obst_wd;
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		if (par_we) par_mem[par_wa] <= dir_q;
		if (queue_we) queue_mem[queue_wa] <= queue_wd;
		if (path_we) path_mem[path_wa] <= path_wd;
		obst_rd_q  <= obst_mem[cell_ra];
		disc_rd_q  <= disc_mem[cell_ra];
		par_rd_q   <= par_mem[cell_ra];
		queue_rd_q <= queue_mem[queue_ra];
		path_rd_q  <= path_mem[path_ra];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= 5'd31;
			end_y_q   <= 5'd31;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbps_pkg::CFG_START_X: start_x_q <= cfg_data;
				gbps_pkg::CFG_START_Y: start_y_q <= cfg_data;
				gbps_pkg::CFG_END_X:   end_x_q   <= cfg_data;
				default:               end_y_q   <= cfg_data;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_INIT;
			clr_q           <= '0;
			head_q          <= '0;
			tail_q          <= '0;
			cnt_q           <= '0;
			pos_q           <= '0;
			cur_x_q         <= '0;
			cur_y_q         <= '0;
			walk_x_q        <= '0;
			walk_y_q        <= '0;
			dir_q           <= '0;
			res_found_q     <= 1'b0;
			res_len_q       <= '0;
			stp_x_q         <= '0;
			stp_y_q         <= '0;
			stp_valid_q     <= 1'b0;
			out_valid_q     <= 1'b0;
			out_found_q     <= 1'b0;
			out_len_q       <= '0;
			out_x_q         <= '0;
			out_y_q         <= '0;
			out_stp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && !load_out) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						stp_x_q     <= '0;
						stp_y_q     <= '0;
						stp_valid_q <= 1'b0;
						clr_q       <= '0;
						unique case (op)
							gbps_pkg::OP_WRITE: state_q <= ST_DONE;
							gbps_pkg::OP_CLEAR: state_q <= ST_CLRO;
							gbps_pkg::OP_SEARCH: begin
								res_found_q <= 1'b0;
								res_len_q   <= '0;
								state_q     <= ST_CLRD;
							end
							default: begin
								if (res_found_q && (cmd.step_index < res_len_q))
									state_q <= ST_RDW;
								else
									state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLRO: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) state_q <= ST_DONE;
				end
				ST_CLRD: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) state_q <= bounds_ok ? ST_CHK : ST_DONE;
				end
				ST_CHK: state_q <= ST_CHKW;
				ST_CHKW: begin
					head_q  <= '0;
					tail_q  <= TW'(1);
					state_q <= obst_rd_q ? ST_DONE : ST_POP;
				end
				// take the next cell off the frontier
				ST_POP: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + TW'(1);
						state_q <= ST_POPW;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_POPW: begin
					cur_x_q <= queue_rd_q[XW-1:0];
					cur_y_q <= queue_rd_q[AW-1:XW];
					dir_q   <= gbps_pkg::DIR_PX;
					if (queue_rd_q == e_addr) begin
						walk_x_q <= ex;
						walk_y_q <= ey;
						cnt_q    <= '0;
						state_q  <= ST_CNT;
					end else begin
						state_q <= ST_NB;
					end
				end
				// neighbour trial
				ST_NB: begin
					if (nb_ok) begin
						state_q <= ST_NBW;
					end else if (dir_q == gbps_pkg::DIR_MY) begin
						state_q <= ST_POP;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ST_NBW: begin
					if (take) tail_q <= tail_q + TW'(1);
					if (dir_q == gbps_pkg::DIR_MY) begin
						state_q <= ST_POP;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= ST_NB;
					end
				end
				// count the steps back to the start
				ST_CNT: begin
					if (walk_at_s) begin
						pos_q    <= cnt_q;
						walk_x_q <= ex;
						walk_y_q <= ey;
						state_q  <= ST_WR;
					end else begin
						state_q <= ST_CNTW;
					end
				end
				ST_CNTW: begin
					walk_x_q <= back_x;
					walk_y_q <= back_y;
					cnt_q    <= cnt_q + TW'(1);
					state_q  <= ST_CNT;
				end
				// store the path, last step first
				ST_WR: begin
					if (walk_at_s || (pos_q == '0)) begin
						res_found_q <= 1'b1;
						res_len_q   <= len_sat ? gbps_pkg::LEN_W'(gbps_pkg::LEN_MAX)
							: gbps_pkg::LEN_W'(cnt_q);
						state_q     <= ST_DONE;
					end else begin
						pos_q   <= pos_q - TW'(1);
						state_q <= ST_WRW;
					end
				end
				ST_WRW: begin
					walk_x_q <= back_x;
					walk_y_q <= back_y;
					state_q  <= ST_WR;
				end
				ST_RDW: begin
					stp_x_q     <= gbps_pkg::COORD_W'(path_rd_q[XW-1:0]);
					stp_y_q     <= gbps_pkg::COORD_W'(path_rd_q[AW-1:XW]);
					stp_valid_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				// hand the word to the output register once it is free
				default: begin
					if (load_out) begin
						out_valid_q     <= 1'b1;
						out_found_q     <= res_found_q;
						out_len_q       <= res_len_q;
						out_x_q         <= stp_x_q;
						out_y_q         <= stp_y_q;
						out_stp_valid_q <= stp_valid_q;
						state_q         <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.path_length = out_len_q;
	assign rsp.step_x      = out_x_q;
	assign rsp.step_y      = out_y_q;
	assign rsp.step_valid  = out_stp_valid_q;

	// checks
	`GBPS_ASSERT(a_queue_order, head_q <= tail_q, "frontier head passed tail")
	`GBPS_ASSERT(a_len_needs_found, res_found_q || (res_len_q == '0), "length without a path")
	`GBPS_ASSERT(a_step_in_path, !(rsp.valid && rsp.step_valid) || rsp.found, "step, no path")
	`GBPS_ASSERT_NEXT(a_busy_after_accept, accept, state_q != ST_IDLE, "accepted but idle")

endmodule
